// File: rtl/core/qde_pkg.sv
// qde_pkg: shared widths, reset values, register indexes and the command
// type of the iterative arithmetic unit for the queue delay estimator.
// No dependencies.
package qde_pkg;

  // Default sizes
  localparam int NPorts      = 16;
  localparam int MaxSnapshot = 1024;

  // Field and state widths
  localparam int PortW    = 4;
  localparam int LenW     = 16;
  localparam int TosW     = 8;
  localparam int RunW     = 26;
  localparam int SumW     = 36;
  localparam int EstW     = 40;
  localparam int CntOutW  = 11;
  localparam int NsW      = 24;
  localparam int WgtW     = 17;
  localparam int InDataW  = 32;
  localparam int OutDataW = 72;

  // Arithmetic unit: accumulator, multiplier operand, divider steps
  localparam int AccW      = 60;
  localparam int MplW      = 24;
  localparam int DivSteps  = 52;
  localparam int ByteShift = 8;   // divide by 256 before the divider
  localparam int WgtShift  = 16;  // Q16 weight scaling

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;
  localparam logic [CfgIdxW-1:0] CfgTosLimit  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNsPerByte = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgNewWeight = 2'd2;

  // Register reset values
  localparam logic [TosW-1:0] TosLimitRst  = 8'd4;
  localparam logic [NsW-1:0]  NsPerByteRst = 24'd256137;
  localparam logic [WgtW-1:0] NewWeightRst = 17'd13107;
  localparam logic [WgtW-1:0] WeightOne    = 17'h10000;

  typedef enum logic [1:0] {
    OP_MUL,   // acc = mcand * mplier
    OP_MAC,   // acc += mcand * mplier
    OP_DIV    // acc = mcand / mplier (restoring)
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_cmd_t;

endpackage

// File: rtl/core/qde_arith.sv
// qde_arith: shared shift-add multiplier and restoring divider, one step
// per cycle, used by the estimator sequencer.
// Depends on qde_pkg.
module qde_arith #(
  parameter int CNT_W = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  qde_pkg::arith_cmd_t         cmd_i,
  input  logic [qde_pkg::AccW-1:0]    mcand_i,
  input  logic [qde_pkg::MplW-1:0]    mplier_i,
  output logic                        done_o,
  output logic [qde_pkg::AccW-1:0]    res_o
);

  localparam int AccW  = qde_pkg::AccW;
  localparam int MplW  = qde_pkg::MplW;
  localparam int StepW = $clog2(qde_pkg::DivSteps);
  localparam logic [StepW-1:0] LastStep = StepW'(qde_pkg::DivSteps - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  qde_pkg::arith_op_e  op_q, op_d;
  logic [AccW-1:0]     acc_q, acc_d;
  logic [AccW-1:0]     mcand_q, mcand_d;
  logic [MplW-1:0]     mplier_q, mplier_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic [StepW-1:0]    step_q, step_d;

  logic [CNT_W:0]      rem_sh;
  logic [CNT_W:0]      div_ext;
  logic                q_bit;

  // Divider step: shift in next dividend bit, subtract if it fits
  assign rem_sh  = {rem_q, acc_q[qde_pkg::DivSteps-1]};
  assign div_ext = {1'b0, mplier_q[CNT_W-1:0]};
  assign q_bit   = (rem_sh >= div_ext);

  // Next-state of the unit
  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    op_d     = op_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    rem_d    = rem_q;
    step_d   = step_q;
    if (cmd_i.start) begin
      busy_d   = 1'b1;
      op_d     = cmd_i.op;
      mcand_d  = mcand_i;
      mplier_d = mplier_i;
      rem_d    = '0;
      step_d   = '0;
      unique case (cmd_i.op)
        qde_pkg::OP_MUL: acc_d = '0;
        qde_pkg::OP_MAC: acc_d = acc_q;
        qde_pkg::OP_DIV: acc_d = mcand_i;
        default:         acc_d = acc_q;
      endcase
    end else if (busy_q) begin
      if (op_q == qde_pkg::OP_DIV) begin
        acc_d  = {acc_q[AccW-2:0], q_bit};
        rem_d  = q_bit ? CNT_W'(rem_sh - div_ext) : rem_sh[CNT_W-1:0];
        step_d = step_q + 1'b1;
        if (step_q == LastStep) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end else if (mplier_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        // shift-add: one multiplier bit a cycle
        acc_d    = acc_q + (mplier_q[0] ? mcand_q : '0);
        mcand_d  = {mcand_q[AccW-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[MplW-1:1]};
      end
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= qde_pkg::OP_MUL;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      step_q <= step_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    rem_q    <= rem_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

// File: rtl/core/queue_delay_ewma_estimator_unit.sv
// queue_delay_ewma_estimator_unit: top level of the per-port queueing delay
// estimator. Depends on qde_pkg and qde_arith.
//
// Packets of a queue snapshot come in one per item; a packet that is not the
// last of its snapshot is taken and the unit is ready again at once. The last
// packet starts the per-snapshot work on the shared shift-add/divide unit: a
// scale multiply that steps through ns_per_byte up to its highest set bit, a
// 52-step divide by the short count, and, when the port already holds a
// non-zero estimate, two smoothing multiplies by the weight and its
// complement. No item is taken after the last packet until the result has
// been loaded into the output register. A snapshot with no short packet, or
// whose port is out of range, gives no result and the unit stays ready.
// Per-port estimates sit in a small memory with a valid bit per port, so
// reset clears them at once without a sweep. The result waits in an output
// register; the next snapshot may start while it is held.
module queue_delay_ewma_estimator_unit #(
  parameter int N_PORTS      = qde_pkg::NPorts,
  parameter int MAX_SNAPSHOT = qde_pkg::MaxSnapshot
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [qde_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [qde_pkg::CfgDataW-1:0]   cfg_data_i,
  // packet items
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // port_index[3:0], pkt_length[19:4], tos_byte[27:20], zero pad
  input  logic [qde_pkg::InDataW-1:0]    s_axis_tdata_i,
  input  logic                           s_axis_tlast_i,   // last_in_snapshot
  // estimate items
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // out_port[3:0], delay_estimate[43:4], short_count[54:44],
  // total_count[65:55], zero pad
  output logic [qde_pkg::OutDataW-1:0]   m_axis_tdata_o
);

  localparam int AW   = (N_PORTS > 1) ? $clog2(N_PORTS) : 1;
  localparam int CW   = $clog2(MAX_SNAPSHOT + 1);
  localparam int RunW = qde_pkg::RunW;
  localparam int SumW = qde_pkg::SumW;
  localparam int EstW = qde_pkg::EstW;
  localparam int AccW = qde_pkg::AccW;
  localparam int MplW = qde_pkg::MplW;
  localparam logic [CW-1:0] CntMax = CW'(MAX_SNAPSHOT);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE_GO,
    S_SCALE_WAIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_OLD_GO,
    S_OLD_WAIT,
    S_NEW_GO,
    S_NEW_WAIT,
    S_EMIT
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [qde_pkg::TosW-1:0] tos_limit_q;
  logic [qde_pkg::NsW-1:0]  ns_per_byte_q;
  logic [qde_pkg::WgtW-1:0] new_weight_q;

  // snapshot accumulators
  logic [RunW-1:0] run_q, run_d;
  logic [SumW-1:0] ws_q, ws_d;
  logic [CW-1:0]   short_q, short_d;
  logic [CW-1:0]   all_q, all_d;

  // job registers
  logic [qde_pkg::PortW-1:0] port_q;
  logic [EstW-1:0]           sample_q;
  logic [EstW-1:0]           est_q;
  logic [EstW-1:0]           old_data_q;
  logic                      old_vld_q;

  // estimate store
  logic [EstW-1:0]    delay_mem [N_PORTS];
  logic [N_PORTS-1:0] vld_q;

  // output register
  logic                           m_tvalid_q, m_tvalid_d;
  logic [qde_pkg::OutDataW-1:0]   m_tdata_q, m_tdata_d;

  // input fields
  logic [qde_pkg::PortW-1:0] in_port;
  logic [qde_pkg::LenW-1:0]  in_len;
  logic [qde_pkg::TosW-1:0]  in_tos;
  logic [7:0]                in_port_ext;
  logic [7:0]                job_port_ext;
  logic [AW-1:0]             in_addr;
  logic [AW-1:0]             job_addr;

  logic            in_fire, emit_fire, out_free;
  logic [RunW:0]   run_sum;
  logic [RunW-1:0] run_new;
  logic [SumW:0]   ws_sum;
  logic [SumW-1:0] ws_new;
  logic [CW-1:0]   short_new, all_new;
  logic            is_short, port_ok, job_ok, old_zero;

  logic [qde_pkg::WgtW-1:0] w_eff, w_comp;
  logic [EstW-1:0]          div_sat;

  qde_pkg::arith_cmd_t arith_cmd;
  logic [AccW-1:0]     arith_mcand;
  logic [MplW-1:0]     arith_mplier;
  logic                arith_done;
  logic [AccW-1:0]     arith_res;

  assign in_port = s_axis_tdata_i[3:0];
  assign in_len  = s_axis_tdata_i[19:4];
  assign in_tos  = s_axis_tdata_i[27:20];

  assign in_port_ext  = 8'(in_port);
  assign job_port_ext = 8'(port_q);
  assign in_addr      = in_port_ext[AW-1:0];
  assign job_addr     = job_port_ext[AW-1:0];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = !m_tvalid_q || m_axis_tready_i;
  assign emit_fire       = (state_q == S_EMIT) && out_free;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tos_limit_q   <= qde_pkg::TosLimitRst;
      ns_per_byte_q <= qde_pkg::NsPerByteRst;
      new_weight_q  <= qde_pkg::NewWeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qde_pkg::CfgTosLimit:  tos_limit_q   <= cfg_data_i[qde_pkg::TosW-1:0];
        qde_pkg::CfgNsPerByte: ns_per_byte_q <= cfg_data_i[qde_pkg::NsW-1:0];
        qde_pkg::CfgNewWeight: new_weight_q  <= cfg_data_i[qde_pkg::WgtW-1:0];
        default: ;
      endcase
    end
  end

  // Per-packet accumulation, saturating
  always_comb begin
    run_sum   = {1'b0, run_q} + (RunW+1)'(in_len);
    run_new   = run_sum[RunW] ? '1 : run_sum[RunW-1:0];
    is_short  = (in_tos <= tos_limit_q);
    ws_sum    = {1'b0, ws_q} + (SumW+1)'(run_new);
    ws_new    = !is_short ? ws_q : (ws_sum[SumW] ? '1 : ws_sum[SumW-1:0]);
    short_new = (is_short && short_q != CntMax) ? short_q + 1'b1 : short_q;
    all_new   = (all_q != CntMax) ? all_q + 1'b1 : all_q;
    port_ok   = ({24'd0, in_port_ext} < 32'(N_PORTS));
    job_ok    = (short_new != '0) && port_ok;
  end

  // Accumulators hold the snapshot through the job and clear on emit or on a dropped snapshot
  always_comb begin
    run_d   = run_q;
    ws_d    = ws_q;
    short_d = short_q;
    all_d   = all_q;
    if ((in_fire && s_axis_tlast_i && !job_ok) || emit_fire) begin
      run_d   = '0;
      ws_d    = '0;
      short_d = '0;
      all_d   = '0;
    end else if (in_fire) begin
      run_d   = run_new;
      ws_d    = ws_new;
      short_d = short_new;
      all_d   = all_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= '0;
      ws_q    <= '0;
      short_q <= '0;
      all_q   <= '0;
    end else begin
      run_q   <= run_d;
      ws_q    <= ws_d;
      short_q <= short_d;
      all_q   <= all_d;
    end
  end

  // Estimate store: registered read on the packet, write on emit
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      old_data_q <= delay_mem[in_addr];
      old_vld_q  <= vld_q[in_addr];
      port_q     <= in_port;
    end
    if (emit_fire) begin
      delay_mem[job_addr] <= est_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (emit_fire) begin
      vld_q[job_addr] <= 1'b1;
    end
  end

  assign old_zero = !old_vld_q || (old_data_q == '0);

  // Smoothing weights, clamped to one
  assign w_eff  = (new_weight_q > qde_pkg::WeightOne) ? qde_pkg::WeightOne : new_weight_q;
  assign w_comp = qde_pkg::WeightOne - w_eff;

  // Quotient saturated to the estimate width
  assign div_sat = (|arith_res[qde_pkg::DivSteps-1:EstW]) ? '1 : arith_res[EstW-1:0];

  // Sample and estimate
  always_ff @(posedge clk_i) begin
    if (state_q == S_DIV_WAIT && arith_done) begin
      sample_q <= div_sat;
      est_q    <= div_sat;
    end else if (state_q == S_NEW_WAIT && arith_done) begin
      est_q <= arith_res[qde_pkg::WgtShift +: EstW];
    end
  end

  // Commands to the shared unit
  always_comb begin
    arith_cmd.start = 1'b0;
    arith_cmd.op    = qde_pkg::OP_MUL;
    arith_mcand     = '0;
    arith_mplier    = '0;
    unique case (state_q)
      S_SCALE_GO: begin
        arith_cmd.start = 1'b1;
        arith_cmd.op    = qde_pkg::OP_MUL;
        arith_mcand     = AccW'(ws_q);
        arith_mplier    = ns_per_byte_q;
      end
      S_DIV_GO: begin
        arith_cmd.start = 1'b1;
        arith_cmd.op    = qde_pkg::OP_DIV;
        arith_mcand     = AccW'(arith_res[AccW-1:qde_pkg::ByteShift]);
        arith_mplier    = MplW'(short_q);
      end
      S_OLD_GO: begin
        arith_cmd.start = 1'b1;
        arith_cmd.op    = qde_pkg::OP_MUL;
        arith_mcand     = AccW'(old_data_q);
        arith_mplier    = MplW'(w_comp);
      end
      S_NEW_GO: begin
        arith_cmd.start = 1'b1;
        arith_cmd.op    = qde_pkg::OP_MAC;
        arith_mcand     = AccW'(sample_q);
        arith_mplier    = MplW'(w_eff);
      end
      default: ;
    endcase
  end

  qde_arith #(
    .CNT_W (CW)
  ) u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (arith_cmd),
    .mcand_i  (arith_mcand),
    .mplier_i (arith_mplier),
    .done_o   (arith_done),
    .res_o    (arith_res)
  );

  // Sequencer and output register
  always_comb begin
    state_d    = state_q;
    m_tvalid_d = m_tvalid_q;
    m_tdata_d  = m_tdata_q;
    if (m_axis_tready_i) m_tvalid_d = 1'b0;
    unique case (state_q)
      S_IDLE:       if (in_fire && s_axis_tlast_i && job_ok) state_d = S_SCALE_GO;
      S_SCALE_GO:   state_d = S_SCALE_WAIT;
      S_SCALE_WAIT: if (arith_done) state_d = S_DIV_GO;
      S_DIV_GO:     state_d = S_DIV_WAIT;
      S_DIV_WAIT:   if (arith_done) state_d = old_zero ? S_EMIT : S_OLD_GO;
      S_OLD_GO:     state_d = S_OLD_WAIT;
      S_OLD_WAIT:   if (arith_done) state_d = S_NEW_GO;
      S_NEW_GO:     state_d = S_NEW_WAIT;
      S_NEW_WAIT:   if (arith_done) state_d = S_EMIT;
      S_EMIT: begin
        if (out_free) begin
          state_d    = S_IDLE;
          m_tvalid_d = 1'b1;
          m_tdata_d  = {6'd0, qde_pkg::CntOutW'(all_q), qde_pkg::CntOutW'(short_q),
                        est_q, port_q};
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      m_tvalid_q <= 1'b0;
      m_tdata_q  <= '0;
    end else begin
      state_q    <= state_d;
      m_tvalid_q <= m_tvalid_d;
      m_tdata_q  <= m_tdata_d;
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;

`ifndef SYNTHESIS
  // short packets never outnumber all packets
  a_short_le_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    short_q <= all_q)
    else $error("short count exceeds total count");

  // an emitted estimate always has at least one short packet
  a_out_has_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_q |-> (m_tdata_q[54:44] != '0))
    else $error("estimate emitted with zero short count");

  // the shared unit only finishes while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_done |-> (state_q == S_SCALE_WAIT || state_q == S_DIV_WAIT ||
                    state_q == S_OLD_WAIT || state_q == S_NEW_WAIT))
    else $error("arithmetic done outside a wait state");

  // emit loads the output register
  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> m_tvalid_q)
    else $error("emit did not present an item");
`endif

endmodule

// File: tb/queue_delay_ewma_estimator_unit_checker.sv
// Checker for queue_delay_ewma_estimator_unit: watches the register port and
// both item channels, predicts each port's smoothed delay and compares.
// Depends on qde_pkg.
`timescale 1ns / 1ps

module queue_delay_ewma_estimator_unit_checker
  import qde_pkg::*;
#(
  parameter int N_PORTS      = NPorts,
  parameter int MAX_SNAPSHOT = MaxSnapshot
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic                s_tlast_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  output int                  fail_count_o,
  output int                  outstanding_o,
  output int                  checked_o
);

  localparam logic [63:0] QueuedMax = (64'd1 << RunW) - 64'd1;
  localparam logic [63:0] SumMax    = (64'd1 << SumW) - 64'd1;
  localparam logic [63:0] EstMax    = (64'd1 << EstW) - 64'd1;
  localparam logic [63:0] Q16One    = 64'd1 << WgtShift;

  typedef struct packed {
    logic [PortW-1:0]   port;
    logic [EstW-1:0]    delay;
    logic [CntOutW-1:0] shorts;
    logic [CntOutW-1:0] total;
  } estimate_t;

  // estimates still owed by the block, oldest first
  estimate_t estimate_q[$];

  // register copies
  logic [TosW-1:0] tos_limit_r;
  logic [NsW-1:0]  ns_per_byte_r;
  logic [WgtW-1:0] new_weight_r;

  // snapshot accumulators and per-port smoothed delay
  logic [63:0]        queued_bytes;
  logic [63:0]        short_sum;
  logic [CntOutW-1:0] n_short;
  logic [CntOutW-1:0] n_all;
  logic [EstW-1:0]    port_est [N_PORTS];

  int fails;
  int checked;

  assign fail_count_o = fails;
  assign checked_o    = checked;

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [PortW-1:0] port;
    logic [LenW-1:0]  len;
    logic [TosW-1:0]  tos;
    logic [63:0]      sample;
    logic [63:0]      old;
    logic [63:0]      wgt;
    logic [63:0]      est;
    estimate_t        seen;
    estimate_t        want;
    if (!rst_ni) begin
      estimate_q.delete();
      tos_limit_r   = TosLimitRst;
      ns_per_byte_r = NsPerByteRst;
      new_weight_r  = NewWeightRst;
      queued_bytes  = '0;
      short_sum     = '0;
      n_short       = '0;
      n_all         = '0;
      for (int p = 0; p < N_PORTS; p++) port_est[p] = '0;
      fails         = 0;
      checked       = 0;
      outstanding_o <= 0;
    end else begin
      // estimate item: compare with the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        seen.port   = m_tdata_i[0 +: PortW];
        seen.delay  = m_tdata_i[PortW +: EstW];
        seen.shorts = m_tdata_i[PortW+EstW +: CntOutW];
        seen.total  = m_tdata_i[PortW+EstW+CntOutW +: CntOutW];
        if (estimate_q.size() == 0) begin
          fails++;
          $error("unexpected estimate item: out_port %0d delay_estimate %0d",
                 seen.port, seen.delay);
        end else begin
          want = estimate_q.pop_front();
          checked++;
          if (seen.port != want.port) begin
            fails++;
            $error("out_port: expected %0d, got %0d", want.port, seen.port);
          end
          if (seen.delay != want.delay) begin
            fails++;
            $error("delay_estimate: expected %0d, got %0d", want.delay, seen.delay);
          end
          if (seen.shorts != want.shorts) begin
            fails++;
            $error("short_count: expected %0d, got %0d", want.shorts, seen.shorts);
          end
          if (seen.total != want.total) begin
            fails++;
            $error("total_count: expected %0d, got %0d", want.total, seen.total);
          end
        end
      end

      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTosLimit:  tos_limit_r   = cfg_data_i[TosW-1:0];
          CfgNsPerByte: ns_per_byte_r = cfg_data_i[NsW-1:0];
          CfgNewWeight: new_weight_r  = cfg_data_i[WgtW-1:0];
          default: ;
        endcase
      end

      // packet item
      if (s_tvalid_i && s_tready_i) begin
        port = s_tdata_i[0 +: PortW];
        len  = s_tdata_i[PortW +: LenW];
        tos  = s_tdata_i[PortW+LenW +: TosW];

        queued_bytes = queued_bytes + 64'(len);
        if (queued_bytes > QueuedMax) queued_bytes = QueuedMax;
        if (n_all < MAX_SNAPSHOT) n_all++;
        if (tos <= tos_limit_r) begin
          short_sum = short_sum + queued_bytes;
          if (short_sum > SumMax) short_sum = SumMax;
          if (n_short < MAX_SNAPSHOT) n_short++;
        end

        if (s_tlast_i) begin
          // no short packet or a port beyond the table: snapshot dropped
          if (n_short != 0 && port < N_PORTS) begin
            sample = (short_sum * 64'(ns_per_byte_r)) / (64'(n_short) << ByteShift);
            if (sample > EstMax) sample = EstMax;
            old = 64'(port_est[port]);
            if (old == 0) begin
              est = sample;
            end else begin
              wgt = (new_weight_r > WeightOne) ? 64'(WeightOne) : 64'(new_weight_r);
              est = (old * (Q16One - wgt) + sample * wgt) >> WgtShift;
            end
            port_est[port] = est[EstW-1:0];
            want.port   = port;
            want.delay  = est[EstW-1:0];
            want.shorts = n_short;
            want.total  = n_all;
            estimate_q.push_back(want);
          end
          queued_bytes = '0;
          short_sum    = '0;
          n_short      = '0;
          n_all        = '0;
        end
      end
      outstanding_o <= estimate_q.size();
    end
  end

endmodule

// File: tb/queue_delay_ewma_estimator_unit_tb.sv
// Testbench top for queue_delay_ewma_estimator_unit: drives packet snapshots,
// register settings and output back-pressure; checking is done by
// queue_delay_ewma_estimator_unit_checker. Depends on qde_pkg.
`timescale 1ns / 1ps

module queue_delay_ewma_estimator_unit_tb;
  import qde_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;  // unmapped index
  localparam int WatchdogLimit = 4000;
  localparam int SettleCycles  = 160;
  localparam int HoldCycles    = 600;

  typedef enum int {
    PRESS_NONE,
    PRESS_HOLD_OFF,
    PRESS_DRAIN
  } pressure_e;

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata  = '0;
  logic                s_tlast  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  int fail_count;
  int outstanding;
  int checked;

  // stimulus controls
  bit        tx_idle_en = 1'b1;
  bit        rx_idle_en = 1'b1;
  bit        hold_req   = 1'b0;
  logic [TosW-1:0] cur_tos = TosLimitRst;
  int        n_items    = 0;
  int        n_settings = 1;

  queue_delay_ewma_estimator_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  queue_delay_ewma_estimator_unit_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tlast_i     (s_tlast),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // receiver: random ready bursts, or a long hold-off on request
  initial begin : receiver
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any accepted item or register write
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("FAIL queue_delay_ewma_estimator_unit");
    $finish;
  end

  // one packet item, with an optional idle burst in front
  task automatic send_packet(input logic [PortW-1:0] port, input logic [LenW-1:0] len,
                             input logic [TosW-1:0] tos, input logic last);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(InDataW-PortW-LenW-TosW){1'b0}}, tos, len, port};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_items++;
  endtask

  // stop sending and wait until every estimate is in
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // drain, then give the block time to finish a snapshot that owes nothing
  task automatic settle();
    drain_results();
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
    if (idx == CfgTosLimit) cur_tos = data[TosW-1:0];
  endtask

  // unused upper data bits are filled at random
  task automatic set_regs(input logic [TosW-1:0] tos, input logic [NsW-1:0] ns,
                          input logic [WgtW-1:0] wgt);
    logic [CfgDataW-1:0] noise;
    noise = CfgDataW'($urandom);
    write_reg(CfgTosLimit, {noise[CfgDataW-1:TosW], tos});
    write_reg(CfgNsPerByte, ns);
    write_reg(CfgNewWeight, {noise[CfgDataW-1:WgtW], wgt});
    n_settings++;
  endtask

  task automatic random_regs();
    logic [TosW-1:0] tos;
    logic [NsW-1:0]  ns;
    logic [WgtW-1:0] wgt;
    case ($urandom_range(0, 3))
      0:       tos = '0;
      1:       tos = '1;
      2:       tos = TosLimitRst;
      default: tos = TosW'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0:       ns = NsW'(1);
      1:       ns = '1;
      2:       ns = NsW'($urandom_range(1, 255));
      3:       ns = NsPerByteRst;
      default: ns = NsW'($urandom_range(1, (1 << NsW) - 1));
    endcase
    case ($urandom_range(0, 4))
      0:       wgt = '0;
      1:       wgt = WeightOne;
      2:       wgt = NewWeightRst;
      3:       wgt = WgtW'($urandom_range(65537, 131071));
      default: wgt = WgtW'($urandom_range(0, 65536));
    endcase
    set_regs(tos, ns, wgt);
  endtask

  function automatic logic [LenW-1:0] pick_length();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return LenW'($urandom_range(1, 64));
      default: return LenW'($urandom);
    endcase
  endfunction

  // type-of-service values cluster around the current limit
  function automatic logic [TosW-1:0] pick_tos();
    case ($urandom_range(0, 6))
      0:       return cur_tos;
      1:       return cur_tos + 8'd1;
      2:       return '0;
      3:       return '1;
      4:       return cur_tos - 8'd1;
      default: return TosW'($urandom);
    endcase
  endfunction

  // random snapshots, mostly short, with at most one pressure event half-way
  task automatic run_phase(input int budget, input pressure_e pressure);
    int start;
    int len;
    bit pressed;
    logic [PortW-1:0] port;
    start   = n_items;
    pressed = 1'b0;
    while (n_items - start < budget) begin
      if (!pressed && n_items - start >= budget / 2) begin
        pressed = 1'b1;
        if (pressure == PRESS_HOLD_OFF) hold_req = 1'b1;
        else if (pressure == PRESS_DRAIN) drain_results();
      end
      port = PortW'($urandom_range(0, NPorts - 1));
      case ($urandom_range(0, 9))
        0:       len = 1;
        7, 8:    len = $urandom_range(9, 24);
        9:       len = $urandom_range(25, 60);
        default: len = $urandom_range(2, 8);
      endcase
      for (int k = 0; k < len; k++) begin
        send_packet(($urandom_range(0, 7) == 0) ? PortW'($urandom) : port,
                    pick_length(), pick_tos(), k == len - 1);
      end
    end
    settle();
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zero-length snapshot, then the same port smoothed
    send_packet(4'd0, 16'd0, 8'd0, 1'b1);
    send_packet(4'd0, 16'hFFFF, 8'd4, 1'b0);
    send_packet(4'd0, 16'd100, 8'd5, 1'b0);
    send_packet(4'd0, 16'd1, 8'hFF, 1'b1);
    send_packet(4'd0, 16'd1500, 8'd0, 1'b1);
    // snapshot without a short packet gives nothing
    send_packet(4'd9, 16'd800, 8'hFF, 1'b0);
    send_packet(4'd9, 16'd64, 8'd5, 1'b1);
    send_packet(4'd15, 16'hFFFF, 8'd0, 1'b0);
    send_packet(4'd15, 16'hFFFF, 8'd3, 1'b1);
    // port field of earlier packets does not matter, the last one decides
    send_packet(4'd2, 16'd40, 8'd1, 1'b0);
    send_packet(4'd11, 16'd1200, 8'd2, 1'b0);
    send_packet(4'd5, 16'd9000, 8'd4, 1'b1);
    settle();

    // strictest limit, largest scale, zero weight keeps the old estimate
    set_regs(8'd0, '1, '0);
    write_reg(CfgSpare, CfgDataW'($urandom));
    send_packet(4'd3, 16'hFFFF, 8'd0, 1'b1);
    send_packet(4'd3, 16'd10, 8'd0, 1'b0);
    send_packet(4'd3, 16'd10, 8'd1, 1'b1);
    send_packet(4'd5, 16'd77, 8'd0, 1'b1);
    settle();

    // everything short, smallest scale, full weight on the new sample
    set_regs(8'hFF, NsW'(1), WeightOne);
    send_packet(4'd3, 16'd7, 8'hFF, 1'b1);
    send_packet(4'd0, 16'd3, 8'h80, 1'b1);
    settle();

    // zero scale, weight above one: estimate drops to zero and restarts
    set_regs(TosLimitRst, '0, '1);
    send_packet(4'd3, 16'd9, 8'd0, 1'b1);
    send_packet(4'd15, 16'd4000, 8'd2, 1'b1);
    settle();

    // random settings and snapshots
    for (int ph = 0; ph < 6; ph++) begin
      random_regs();
      if (ph == 5) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      run_phase(140, (ph == 1) ? PRESS_HOLD_OFF : (ph == 3) ? PRESS_DRAIN : PRESS_NONE);
    end

    $display("Sent %0d packet items under %0d register settings; %0d estimates checked.",
             n_items, n_settings, checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS queue_delay_ewma_estimator_unit");
    end else begin
      $display("FAIL queue_delay_ewma_estimator_unit");
    end
    $finish;
  end

endmodule
